// File: rtl/ttgq_pkg.sv
// Package: types, character codes and color table of the tagged text glyph quad generator.
package ttgq_pkg;

    // Longest text in bytes; later bytes are dropped
    localparam int MAX_TEXT = 256;
    localparam int CNT_W    = $clog2(MAX_TEXT + 1);

    // Parser modes
    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_OPEN,
        MODE_NAME,
        MODE_SKIP
    } mode_t;

    // Character codes
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] GLYPH_BASE = 8'd32;

    localparam logic [7:0] CELL_MAX    = 8'd255;
    localparam logic [3:0] WHITE_INDEX = 4'd0;

    localparam logic KIND_GLYPH  = 1'b0;
    localparam logic KIND_EXTENT = 1'b1;

    // Name hashes of the color table
    localparam logic [31:0] COLOR_HASH [16] = '{
        32'd3489,  32'd7125,  32'd6899,  32'd758,
        32'd13305, 32'd7133,  32'd1551,  32'd1580,
        32'd3276,  32'd52012, 32'd3272,  32'd768,
        32'd54467, 32'd108275, 32'd25971, 32'd3125
    };

    // RGB of the color table, {red, green, blue}
    localparam logic [23:0] COLOR_RGB [16] = '{
        {8'd255, 8'd255, 8'd255}, {8'd251, 8'd243, 8'd5},
        {8'd255, 8'd100, 8'd3},   {8'd221, 8'd9,   8'd7},
        {8'd242, 8'd8,   8'd132}, {8'd71,  8'd0,   8'd165},
        {8'd0,   8'd0,   8'd211}, {8'd2,   8'd171, 8'd234},
        {8'd31,  8'd183, 8'd20},  {8'd0,   8'd100, 8'd18},
        {8'd86,  8'd44,  8'd5},   {8'd144, 8'd113, 8'd58},
        {8'd192, 8'd192, 8'd192}, {8'd128, 8'd128, 8'd128},
        {8'd64,  8'd64,  8'd64},  {8'd0,   8'd0,   8'd0}
    };

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic [3:0] glyph_col;
        logic [3:0] glyph_row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] ext_width;
        logic [8:0] ext_height;
        logic       last_result;
    } result_t;

    // Up to three results of one input item, in output order
    typedef struct packed {
        logic [2:0]         valid;
        result_t [2:0]      item;
    } batch_t;

    // Glyph record at a cell with the given character and color
    function automatic result_t make_glyph(input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] code, input logic [23:0] rgb);
        result_t    r;
        logic [7:0] idx;
        idx           = code - GLYPH_BASE;
        r             = '0;
        r.kind        = KIND_GLYPH;
        r.cell_x      = x;
        r.cell_y      = y;
        r.glyph_col   = idx[3:0];
        r.glyph_row   = idx[7:4];
        r.red         = rgb[23:16];
        r.green       = rgb[15:8];
        r.blue        = rgb[7:0];
        return r;
    endfunction

endpackage

// File: rtl/ttgq_color_rom.sv
// Color ROM: synchronous read of the RGB table.
module ttgq_color_rom (
    input  logic        aclk,
    input  logic [3:0]  addr,
    output logic [23:0] rgb
);

    logic [23:0] rgb_reg;

    // Registered read of the constant table
    always_ff @(posedge aclk) begin
        rgb_reg <= ttgq_pkg::COLOR_RGB[addr];
    end

    assign rgb = rgb_reg;

endmodule

// File: rtl/ttgq_parser.sv
// Parser: per-item update of cursor, tag and color state, builds the results of each item.
module ttgq_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    input  logic [23:0]       rgb,
    output logic [3:0]        color_addr,
    output ttgq_pkg::batch_t  batch
);

    ttgq_pkg::mode_t            mode_reg, mode_next;
    logic [31:0]                hash_reg, hash_next;
    logic [7:0]                 cx_reg, cx_next;
    logic [7:0]                 cy_reg, cy_next;
    logic [7:0]                 wx_reg, wx_next;
    logic [3:0]                 cidx_reg, cidx_next;
    logic [ttgq_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       do_plain;
    ttgq_pkg::batch_t           b;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ttgq_pkg::MODE_TEXT;
            hash_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            wx_reg    <= '0;
            cidx_reg  <= ttgq_pkg::WHITE_INDEX;
            count_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            hash_reg  <= hash_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            wx_reg    <= wx_next;
            cidx_reg  <= cidx_next;
            count_reg <= count_next;
        end
    end

    // Next state and results of the accepted item
    always_comb begin
        mode_next  = mode_reg;
        hash_next  = hash_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        wx_next    = wx_reg;
        cidx_next  = cidx_reg;
        count_next = count_reg;
        do_plain   = 1'b0;
        b          = '0;

        if (accept) begin
            if (count_reg < ttgq_pkg::CNT_W'(ttgq_pkg::MAX_TEXT)) begin
                count_next = count_reg + 1'b1;
                unique case (mode_reg)
                    ttgq_pkg::MODE_OPEN: begin
                        if (char_code == ttgq_pkg::CHAR_HASH) begin
                            hash_next = '0;
                            mode_next = ttgq_pkg::MODE_NAME;
                        end else if (char_code == ttgq_pkg::CHAR_SLASH) begin
                            cidx_next = ttgq_pkg::WHITE_INDEX;
                            mode_next = ttgq_pkg::MODE_SKIP;
                        end else begin
                            // pending '<' opened no tag: draw it, then the byte
                            mode_next    = ttgq_pkg::MODE_TEXT;
                            b.valid[0]   = 1'b1;
                            b.item[0]    = ttgq_pkg::make_glyph(cx_reg, cy_reg,
                                                                ttgq_pkg::CHAR_LT, rgb);
                            if (cx_reg > wx_reg) begin
                                wx_next = cx_reg;
                            end
                            if (cx_reg < ttgq_pkg::CELL_MAX) begin
                                cx_next = cx_reg + 1'b1;
                            end
                            do_plain = 1'b1;
                        end
                    end
                    ttgq_pkg::MODE_NAME: begin
                        if (char_code == ttgq_pkg::CHAR_GT) begin
                            // first matching entry wins; unknown keeps the color
                            for (int i = 15; i >= 0; i--) begin
                                if (hash_reg == ttgq_pkg::COLOR_HASH[i]) begin
                                    cidx_next = 4'(i);
                                end
                            end
                            mode_next = ttgq_pkg::MODE_TEXT;
                        end else begin
                            hash_next = {hash_reg[30:0], 1'b0} + {24'd0, char_code};
                        end
                    end
                    ttgq_pkg::MODE_SKIP: begin
                        mode_next = ttgq_pkg::MODE_TEXT;
                    end
                    default: begin
                        do_plain = 1'b1;
                    end
                endcase

                // Plain text byte
                if (do_plain) begin
                    if (char_code == ttgq_pkg::CHAR_LT && !last_char) begin
                        mode_next = ttgq_pkg::MODE_OPEN;
                    end else if (char_code == ttgq_pkg::CHAR_NL) begin
                        cx_next = '0;
                        if (cy_reg < ttgq_pkg::CELL_MAX) begin
                            cy_next = cy_reg + 1'b1;
                        end
                    end else begin
                        b.valid[1] = 1'b1;
                        b.item[1]  = ttgq_pkg::make_glyph(cx_next, cy_reg, char_code, rgb);
                        if (cx_next > wx_next) begin
                            wx_next = cx_next;
                        end
                        if (cx_next < ttgq_pkg::CELL_MAX) begin
                            cx_next = cx_next + 1'b1;
                        end
                    end
                end
            end

            // End of text: extent record, then back to reset state
            if (last_char) begin
                b.valid[2]           = 1'b1;
                b.item[2].kind       = ttgq_pkg::KIND_EXTENT;
                b.item[2].ext_width  = {1'b0, wx_next} + 9'd1;
                b.item[2].ext_height = {1'b0, cy_next} + 9'd1;
                mode_next  = ttgq_pkg::MODE_TEXT;
                hash_next  = '0;
                cx_next    = '0;
                cy_next    = '0;
                wx_next    = '0;
                cidx_next  = ttgq_pkg::WHITE_INDEX;
                count_next = '0;
            end

            // Mark the final result of this item
            priority if (b.valid[2]) begin
                b.item[2].last_result = 1'b1;
            end else if (b.valid[1]) begin
                b.item[1].last_result = 1'b1;
            end else if (b.valid[0]) begin
                b.item[0].last_result = 1'b1;
            end else begin
                b.item[0].last_result = 1'b0;
            end
        end
    end

    // ROM address tracks the next color index so its data matches the index register
    assign color_addr = aresetn ? cidx_next : ttgq_pkg::WHITE_INDEX;
    assign batch      = b;

endmodule

// File: rtl/ttgq_result_queue.sv
// Result queue: four-entry buffer taking up to three results per cycle, one out per cycle while out_ready is high.
module ttgq_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  ttgq_pkg::batch_t  batch,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output ttgq_pkg::result_t out_item
);

    ttgq_pkg::result_t q_mem [4];
    logic [1:0]        wr_ptr_reg, wr_ptr_next;
    logic [1:0]        rd_ptr_reg, rd_ptr_next;
    logic [2:0]        count_reg, count_next;
    logic [1:0]        off [3];
    logic [1:0]        push_n;
    logic              pop;

    // Slot offsets of the valid results
    always_comb begin
        off[0] = 2'd0;
        off[1] = {1'b0, batch.valid[0]};
        off[2] = {1'b0, batch.valid[0]} + {1'b0, batch.valid[1]};
        push_n = off[2] + {1'b0, batch.valid[2]};
    end

    // Pointers and fill count
    assign pop         = out_valid && out_ready;
    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry writes
    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            if (batch.valid[j]) begin
                q_mem[wr_ptr_reg + off[j]] <= batch.item[j];
            end
        end
    end

    // Room for a full three-result item
    assign room      = (count_reg <= 3'd1);
    assign out_valid = (count_reg != 3'd0);
    assign out_item  = q_mem[rd_ptr_reg];

endmodule

// File: rtl/tagged_text_glyph_quad_generator_core.sv
// Top level: tagged text glyph quad generator, parser, color ROM and result queue.
// Results are written into the result queue and offered from it in order.
// Throughput: one item per cycle while results drain at the same rate; an item
// yields zero to three results, and the four-entry result queue accepts a
// new item while it holds at most one result.
// Reset: aresetn synchronous, active low; clears cursor, tag, color and queue state.
module tagged_text_glyph_quad_generator_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_cell_x,
    output logic [7:0] m_cell_y,
    output logic [3:0] m_glyph_col,
    output logic [3:0] m_glyph_row,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic [8:0] m_ext_width,
    output logic [8:0] m_ext_height,
    output logic       m_last_result
);

    logic              accept;
    logic [3:0]        color_addr;
    logic [23:0]       rgb;
    ttgq_pkg::batch_t  batch;
    ttgq_pkg::result_t out_item;

    assign accept = s_valid && s_ready;

    ttgq_color_rom u_rom (
        .aclk (aclk),
        .addr (color_addr),
        .rgb  (rgb)
    );

    ttgq_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .char_code  (s_char_code),
        .last_char  (s_last_char),
        .rgb        (rgb),
        .color_addr (color_addr),
        .batch      (batch)
    );

    ttgq_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .batch     (batch),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (out_item)
    );

    // Result fields
    assign m_kind        = out_item.kind;
    assign m_cell_x      = out_item.cell_x;
    assign m_cell_y      = out_item.cell_y;
    assign m_glyph_col   = out_item.glyph_col;
    assign m_glyph_row   = out_item.glyph_row;
    assign m_red         = out_item.red;
    assign m_green       = out_item.green;
    assign m_blue        = out_item.blue;
    assign m_ext_width   = out_item.ext_width;
    assign m_ext_height  = out_item.ext_height;
    assign m_last_result = out_item.last_result;

endmodule
